[hdl/soab_pkg.sv]
// Shared constants, types and arithmetic helpers for the surface alpha blend block.
// Depends on nothing; used by hdl/surface_alpha_over_blend.sv.
`timescale 1ns / 1ps
`default_nettype none

package soab_pkg;

	localparam int unsigned PIX_W     = 32;
	localparam int unsigned CHAN_W    = 8;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SURFACE_ALPHA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_KEY     = 2'd2;

	// Colour lanes, numbered by their byte position in the pixel.
	localparam int unsigned LANES  = 3;
	localparam int unsigned LANE_B = 0;
	localparam int unsigned LANE_G = 1;
	localparam int unsigned LANE_R = 2;

	// Divider numerator width and how many restoring steps each stage does.
	localparam int unsigned NUM_W           = 18;
	localparam int unsigned STEPS_PER_STAGE = 3;
	localparam int unsigned DIV_STAGES      = NUM_W / STEPS_PER_STAGE;
	// Input register, two multiply stages, numerator stage, divider, output register.
	localparam int unsigned PIPE_DEPTH      = DIV_STAGES + 5;

	typedef struct packed {
		logic [CHAN_W-1:0] rem;
		logic [NUM_W-1:0]  num;
		logic [CHAN_W-1:0] quo;
		logic [CHAN_W-1:0] raw;
	} div_lane_t;

	typedef struct packed {
		logic                   keyed;
		logic [CHAN_W-1:0]      alpha;
		logic [PIX_W-1:0]       dst;
		div_lane_t [LANES-1:0]  lane;
	} div_stage_t;

	// One restoring division step: returns the quotient bit above the new remainder.
	function automatic logic [CHAN_W:0] div_step(input logic [CHAN_W-1:0] rem,
			input logic nb, input logic [CHAN_W-1:0] dvs);
		logic [CHAN_W:0] part;
		logic [CHAN_W:0] diff;
		part = {rem, nb};
		diff = part - {1'b0, dvs};
		if (part >= {1'b0, dvs}) begin
			return {1'b1, diff[CHAN_W-1:0]};
		end
		return {1'b0, part[CHAN_W-1:0]};
	endfunction

	// Exact floor(x / 255) for any product of two bytes.
	function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] x);
		logic [2*CHAN_W:0] t;
		t = {1'b0, x} + {{(CHAN_W+1){1'b0}}, x[2*CHAN_W-1:CHAN_W]} + 17'd1;
		return t[2*CHAN_W-1:CHAN_W];
	endfunction

endpackage

`default_nettype wire

[hdl/surface_alpha_over_blend.sv]
// Top level of the surface alpha "over" blend: config registers, blend pipeline and divider.
// Depends on hdl/soab_pkg.sv.
`timescale 1ns / 1ps
`default_nettype none

// One pixel pair is taken on every clock at which start is high; busy is never raised, so
// the block sustains one pixel per clock. Each pixel gives exactly one result, shown for a
// single cycle with result_valid high, from the registered output stage; the
// receiver cannot stall the pipeline and must take every result. Most of the pipeline is
// the per-channel division by the output alpha, an 18-step restoring divider spread over
// six stages of three steps, behind an input stage, two multiply stages and a numerator
// stage, with a registered output. Configuration writes are always accepted and apply to
// pixels started after the write; they should only be made while no pixel is in flight.
module surface_alpha_over_blend (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [soab_pkg::PIX_W-1:0]     source_pixel,
	input  wire logic [soab_pkg::PIX_W-1:0]     dest_pixel,
	output logic                                result_valid,
	output logic [soab_pkg::PIX_W-1:0]          blended_pixel,
	output logic                                write_enable,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [soab_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [soab_pkg::PIX_W-1:0]     cfg_data
);

	localparam int unsigned CW = soab_pkg::CHAN_W;
	localparam int unsigned PW = soab_pkg::PIX_W;
	localparam int unsigned NL = soab_pkg::LANES;
	localparam int unsigned DS = soab_pkg::DIV_STAGES;
	localparam int unsigned NW = soab_pkg::NUM_W;

	// Configuration registers.
	logic [CW-1:0] surface_alpha_q;
	logic          key_enable_q;
	logic [PW-1:0] color_key_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surface_alpha_q <= soab_pkg::CHAN_MAX;
			key_enable_q    <= 1'b0;
			color_key_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				soab_pkg::REG_SURFACE_ALPHA: surface_alpha_q <= cfg_data[CW-1:0];
				soab_pkg::REG_KEY_ENABLE:    key_enable_q    <= cfg_data[0];
				soab_pkg::REG_COLOR_KEY:     color_key_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: capture the beat and decide colour keying.
	logic          valid_s1;
	logic          keyed_s1;
	logic [PW-1:0] src_s1;
	logic [PW-1:0] dst_s1;
	logic [CW-1:0] sa_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		keyed_s1 <= key_enable_q && (source_pixel == color_key_q);
		src_s1   <= source_pixel;
		dst_s1   <= dest_pixel;
		sa_s1    <= surface_alpha_q;
	end

	// Stage 2: first round of byte products.
	logic            valid_s2;
	logic            keyed_s2;
	logic [PW-1:0]   dst_s2;
	logic [CW-1:0]   sa_s2;
	logic [CW-1:0]   da_s2;
	logic [2*CW-1:0] sada_s2;
	logic [2*CW-1:0] dmul_s2 [NL];
	logic [2*CW-1:0] smul_s2 [NL];
	logic [CW-1:0]   inv_sa;

	assign inv_sa = soab_pkg::CHAN_MAX - sa_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		keyed_s2 <= keyed_s1;
		dst_s2   <= dst_s1;
		sa_s2    <= sa_s1;
		da_s2    <= dst_s1[PW-1 -: CW];
		sada_s2  <= {{CW{1'b0}}, sa_s1} * {{CW{1'b0}}, dst_s1[PW-1 -: CW]};
		for (int l = 0; l < NL; l++) begin
			dmul_s2[l] <= {{CW{1'b0}}, dst_s1[CW*l +: CW]} * {{CW{1'b0}}, inv_sa};
			smul_s2[l] <= {{CW{1'b0}}, src_s1[CW*l +: CW]} * {{CW{1'b0}}, sa_s1};
		end
	end

	// Stage 3: scale the destination terms by its alpha and form the output alpha.
	logic            valid_s3;
	logic            keyed_s3;
	logic [PW-1:0]   dst_s3;
	logic [CW-1:0]   alpha_s3;
	logic [3*CW-1:0] dtri_s3 [NL];
	logic [2*CW-1:0] smul_s3 [NL];
	logic [CW:0]     alpha_sum;

	assign alpha_sum = {1'b0, sa_s2} + {1'b0, da_s2} - {1'b0, soab_pkg::div255(sada_s2)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		keyed_s3 <= keyed_s2;
		dst_s3   <= dst_s2;
		alpha_s3 <= alpha_sum[CW-1:0];
		for (int l = 0; l < NL; l++) begin
			dtri_s3[l] <= {{CW{1'b0}}, dmul_s2[l]} * {{(2*CW){1'b0}}, da_s2};
			smul_s3[l] <= smul_s2[l];
		end
	end

	// Stage 4: channel sums, shifted down so that the wanted quotient byte is the lowest.
	// Only the bits above the lane's byte position are kept, as floor(floor(x/2^k)/a)
	// equals floor(floor(x/a)/2^k).
	logic [PW-1:0]       red_sum;
	logic [3*CW:0]       green_sum;
	logic [2*CW:0]       blue_sum;
	logic [NW-1:0]       num_in [NL];
	soab_pkg::div_stage_t div_in;

	assign red_sum   = {dtri_s3[soab_pkg::LANE_R], {CW{1'b0}}}
			+ {smul_s3[soab_pkg::LANE_R], {(2*CW){1'b0}}};
	assign green_sum = {1'b0, dtri_s3[soab_pkg::LANE_G]}
			+ {1'b0, smul_s3[soab_pkg::LANE_G], {CW{1'b0}}};
	assign blue_sum  = {1'b0, dtri_s3[soab_pkg::LANE_B][3*CW-1:CW]}
			+ {1'b0, smul_s3[soab_pkg::LANE_B]};

	always_comb begin
		num_in[soab_pkg::LANE_R] = {{(NW-2*CW){1'b0}}, red_sum[PW-1:2*CW]};
		num_in[soab_pkg::LANE_G] = {{(NW-2*CW-1){1'b0}}, green_sum[3*CW:CW]};
		num_in[soab_pkg::LANE_B] = {{(NW-2*CW-1){1'b0}}, blue_sum};
		div_in.keyed = keyed_s3;
		div_in.alpha = alpha_s3;
		div_in.dst   = dst_s3;
		for (int l = 0; l < NL; l++) begin
			div_in.lane[l].rem = '0;
			div_in.lane[l].num = num_in[l];
			div_in.lane[l].quo = '0;
			div_in.lane[l].raw = num_in[l][CW-1:0];
		end
	end

	// Divider pipeline: element 0 is stage 4, element DS is stage 10.
	logic                 div_vld_s [DS+1];
	soab_pkg::div_stage_t div_s     [DS+1];
	soab_pkg::div_stage_t div_nxt   [1:DS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_vld_s[0] <= 1'b0;
		end else begin
			div_vld_s[0] <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		div_s[0] <= div_in;
	end

	for (genvar k = 1; k <= DS; k++) begin : g_div
		always_comb begin
			soab_pkg::div_stage_t st;
			logic [CW:0]          res;
			st = div_s[k-1];
			for (int l = 0; l < NL; l++) begin
				for (int j = 0; j < soab_pkg::STEPS_PER_STAGE; j++) begin
					res = soab_pkg::div_step(st.lane[l].rem, st.lane[l].num[NW-1], st.alpha);
					st.lane[l].rem = res[CW-1:0];
					st.lane[l].num = {st.lane[l].num[NW-2:0], 1'b0};
					st.lane[l].quo = {st.lane[l].quo[CW-2:0], res[CW]};
				end
			end
			div_nxt[k] = st;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s[k] <= 1'b0;
			end else begin
				div_vld_s[k] <= div_vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			div_s[k] <= div_nxt[k];
		end
	end

	// Stage 11: output register. With zero output alpha no division applies.
	soab_pkg::div_stage_t fin;
	logic [PW-1:0]        blend_word;

	assign fin = div_s[DS];

	always_comb begin
		blend_word[PW-1 -: CW] = fin.alpha;
		for (int l = 0; l < NL; l++) begin
			blend_word[CW*l +: CW] = (fin.alpha == '0) ? fin.lane[l].raw : fin.lane[l].quo;
		end
	end

	logic          valid_s11;
	logic [PW-1:0] pixel_s11;
	logic          we_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
		end else begin
			valid_s11 <= div_vld_s[DS];
		end
	end

	always_ff @(posedge clk) begin
		pixel_s11 <= fin.keyed ? fin.dst : blend_word;
		we_s11    <= !fin.keyed;
	end

	assign result_valid  = valid_s11;
	assign blended_pixel = pixel_s11;
	assign write_enable  = we_s11;

`ifndef NO_ASSERTIONS
	// A suppressed write can only come from a beat that matched the colour key.
	a_keyed_origin: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !write_enable |->
			$past(valid_s1 && keyed_s1, soab_pkg::PIPE_DEPTH - 1))
		else $error("suppressed write without a keyed source beat");

	// The alpha byte of a written result is the alpha formed in stage 3.
	a_alpha_carried: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && write_enable |->
			blended_pixel[PW-1 -: CW] == $past(alpha_s3, soab_pkg::PIPE_DEPTH - 3))
		else $error("output alpha differs from the alpha formed in stage 3");

	// Output alpha is zero only when both source and destination alpha are zero.
	a_alpha_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && alpha_s3 == '0 |-> $past(sa_s2 == '0 && da_s2 == '0))
		else $error("zero output alpha from nonzero input alpha");

	// Every beat that enters the divider leaves it as a result.
	a_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld_s[0] |-> ##(DS + 1) result_valid)
		else $error("beat lost in the divider pipeline");
`endif

endmodule

`default_nettype wire
